// File: design/wfs_pkg.sv
`timescale 1ns / 1ps

package wfs_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int RT_W   = 32;
  localparam int WC_W   = 3;
  localparam int RCNT_W = 16;
  localparam int ID_W   = 16;
  localparam int WU_W   = 10;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [RT_W-1:0]   runtime;
    logic [WC_W-1:0]   wclass;
    logic [RCNT_W-1:0] count;
    logic [ID_W-1:0]   id;
  } entry_t;

  // Runtime advance per slice in units of 1/400 slice; the unused classes
  // (4 to 7) take the largest advance, 625.
  function automatic logic [WU_W-1:0] weight_units(input logic [WC_W-1:0] wc);
    logic [WU_W-1:0] w;
    unique case (wc)
      3'd0:    w = 10'd256;
      3'd1:    w = 10'd320;
      3'd2:    w = 10'd400;
      3'd3:    w = 10'd500;
      default: w = 10'd625;
    endcase
    return w;
  endfunction

endpackage

// File: design/wfs_table_ram.sv
`timescale 1ns / 1ps

module wfs_table_ram
  import wfs_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/weighted_fair_scheduler_core.sv
`timescale 1ns / 1ps

// Weighted fair scheduler. Every transfer on the input channel gives exactly one
// transfer on the output channel. An add, or a tick on an empty table, has its
// result registered in the next cycle. A tick sorts the task table by virtual
// runtime with an exchange sort (one compare per cycle through the one read port
// of the table memory), charges the head task and removes it when its run count
// hits run_limit, shifting the later tasks down; a tick on a lone task goes
// straight to the charge. The input stalls for the whole tick and while a
// previous result still waits on the output.
module weighted_fair_scheduler_core
  import wfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [RCNT_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [WC_W-1:0]   in_weight_class,
  input  logic [ID_W-1:0]   in_task_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_add_accepted,
  output logic              out_selected_valid,
  output logic [ID_W-1:0]   out_selected_id,
  output logic              out_finished,
  output logic              out_all_done
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOADI, ST_CMP, ST_WRI, ST_RD0, ST_HEAD, ST_SHIFT, ST_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  live_r, live_nxt;
  logic [RCNT_W-1:0] added_r, added_nxt;
  logic [RCNT_W-1:0] fin_cnt_r, fin_cnt_nxt;
  logic [RCNT_W-1:0] run_limit_r;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  entry_t            cur_r, cur_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic              res_fin_r, res_fin_nxt;
  logic              res_all_r, res_all_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_add_r, out_add_nxt;
  logic              out_sel_r, out_sel_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic              out_fin_r, out_fin_nxt;
  logic              out_all_r, out_all_nxt;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  entry_t            mem_rdata;

  logic              out_free;
  logic              in_xfer;
  logic [CNT_W-1:0]  live_m1;
  logic [RT_W:0]     rt_sum;
  entry_t            head_upd;
  logic [RCNT_W-1:0] fin_inc;

  wfs_table_ram u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == ST_IDLE && out_free);
  assign in_xfer  = in_valid && !in_stall;
  assign live_m1  = live_r - CNT_W'(1);
  assign fin_inc  = fin_cnt_r + RCNT_W'(1);

  // The adder charges the head task; runtime saturates at all ones.
  always_comb begin
    rt_sum            = {1'b0, mem_rdata.runtime}
                        + (RT_W + 1)'(weight_units(mem_rdata.wclass));
    head_upd          = mem_rdata;
    head_upd.runtime  = rt_sum[RT_W] ? {RT_W{1'b1}} : rt_sum[RT_W-1:0];
    head_upd.count    = mem_rdata.count + RCNT_W'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    live_nxt      = live_r;
    added_nxt     = added_r;
    fin_cnt_nxt   = fin_cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    res_id_nxt    = res_id_r;
    res_fin_nxt   = res_fin_r;
    res_all_nxt   = res_all_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_add_nxt   = out_add_r;
    out_sel_nxt   = out_sel_r;
    out_id_nxt    = out_id_r;
    out_fin_nxt   = out_fin_r;
    out_all_nxt   = out_all_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = cur_r;
    mem_raddr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_operation == OP_ADD || live_r == '0) begin
            // Adds and ticks on an empty table finish in this cycle.
            out_valid_nxt = 1'b1;
            out_add_nxt   = 1'b0;
            out_sel_nxt   = 1'b0;
            out_id_nxt    = '0;
            out_fin_nxt   = 1'b0;
            out_all_nxt   = 1'b0;
            if (in_operation == OP_ADD && live_r < CNT_W'(MAX_TASKS)) begin
              mem_we            = 1'b1;
              mem_waddr         = live_r[IDX_W-1:0];
              mem_wdata.runtime = '0;
              mem_wdata.wclass  = in_weight_class;
              mem_wdata.count   = '0;
              mem_wdata.id      = in_task_id;
              live_nxt          = live_r + CNT_W'(1);
              added_nxt         = added_r + RCNT_W'(1);
              out_add_nxt       = 1'b1;
            end
          end else if (live_r == CNT_W'(1)) begin
            state_nxt = ST_HEAD;
          end else begin
            i_nxt     = '0;
            state_nxt = ST_LOADI;
          end
        end
      end

      ST_LOADI: begin
        cur_nxt   = mem_rdata;
        j_nxt     = i_r + IDX_W'(1);
        mem_raddr = i_r + IDX_W'(1);
        state_nxt = ST_CMP;
      end

      // cur_r holds the running minimum for position i; a smaller entry at j
      // takes its place and the old one is written back at j.
      ST_CMP: begin
        if (cur_r.runtime > mem_rdata.runtime) begin
          mem_we    = 1'b1;
          mem_waddr = j_r;
          mem_wdata = cur_r;
          cur_nxt   = mem_rdata;
        end
        if ({1'b0, j_r} == live_m1) begin
          state_nxt = ST_WRI;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          mem_raddr = j_r + IDX_W'(1);
        end
      end

      ST_WRI: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = cur_r;
        i_nxt     = i_r + IDX_W'(1);
        if ({1'b0, i_r} + CNT_W'(2) == live_r) begin
          state_nxt = ST_RD0;
        end else begin
          mem_raddr = i_r + IDX_W'(1);
          state_nxt = ST_LOADI;
        end
      end

      ST_RD0: begin
        state_nxt = ST_HEAD;
      end

      ST_HEAD: begin
        res_id_nxt  = mem_rdata.id;
        res_fin_nxt = 1'b0;
        res_all_nxt = 1'b0;
        if (head_upd.count == run_limit_r) begin
          res_fin_nxt = 1'b1;
          res_all_nxt = (fin_inc == added_r);
          fin_cnt_nxt = fin_inc;
          if (live_r == CNT_W'(1)) begin
            live_nxt  = live_m1;
            state_nxt = ST_DONE;
          end else begin
            k_nxt     = IDX_W'(1);
            mem_raddr = IDX_W'(1);
            state_nxt = ST_SHIFT;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = head_upd;
          state_nxt = ST_DONE;
        end
      end

      ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = k_r - IDX_W'(1);
        mem_wdata = mem_rdata;
        if ({1'b0, k_r} == live_m1) begin
          live_nxt  = live_m1;
          state_nxt = ST_DONE;
        end else begin
          k_nxt     = k_r + IDX_W'(1);
          mem_raddr = k_r + IDX_W'(1);
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_add_nxt   = 1'b0;
          out_sel_nxt   = 1'b1;
          out_id_nxt    = res_id_r;
          out_fin_nxt   = res_fin_r;
          out_all_nxt   = res_all_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      live_r      <= '0;
      added_r     <= '0;
      fin_cnt_r   <= '0;
      run_limit_r <= RCNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      added_r     <= added_nxt;
      fin_cnt_r   <= fin_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        run_limit_r <= cfg_wdata;
      end
    end
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    cur_r     <= cur_nxt;
    res_id_r  <= res_id_nxt;
    res_fin_r <= res_fin_nxt;
    res_all_r <= res_all_nxt;
    out_add_r <= out_add_nxt;
    out_sel_r <= out_sel_nxt;
    out_id_r  <= out_id_nxt;
    out_fin_r <= out_fin_nxt;
    out_all_r <= out_all_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_add_accepted   = out_add_r;
  assign out_selected_valid = out_sel_r;
  assign out_selected_id    = out_id_r;
  assign out_finished       = out_fin_r;
  assign out_all_done       = out_all_r;

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CNT_W'(MAX_TASKS))
    else $error("live task count exceeds the table size");

  a_cmp_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> (j_r > i_r && {1'b0, j_r} < live_r))
    else $error("sort compare index out of order or out of range");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_add_r && out_sel_r) && (!out_fin_r || out_sel_r)
                    && (!out_all_r || out_fin_r))
    else $error("inconsistent result flags");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_operation == OP_ADD && live_r == CNT_W'(MAX_TASKS)
      |=> live_r == CNT_W'(MAX_TASKS) && !out_add_r)
    else $error("add to a full table was stored");
`endif

endmodule
